[design/dsefr_pkg.sv]
package dsefr_pkg;

  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_DLE = 8'h10;

  localparam int unsigned CountW = 17;
  localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd256;

  // APB word index of the only register
  localparam logic REG_MAX_PAYLOAD = 1'b0;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_STX  = 2'd1,
    PH_DATA = 2'd2,
    PH_ESC  = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    EV_NONE    = 4'd0,
    EV_DATA    = 4'd1,
    EV_DONE    = 4'd2,
    EV_NOSTX   = 4'd3,
    EV_NOBUF   = 4'd4,
    EV_OVF     = 4'd5,
    EV_RESTART = 4'd6,
    EV_BADESC  = 4'd7,
    EV_LINE    = 4'd8
  } event_e;

  // clamp a 17-bit count to 16 bits
  function automatic logic [15:0] sat16(input logic [CountW-1:0] v);
    logic [15:0] r;
    r = v[CountW-1] ? 16'hFFFF : v[15:0];
    return r;
  endfunction

endpackage

[design/dsefr_in_if.sv]
interface dsefr_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;
  logic       buffer_available;

  modport source (output valid, kind, rx_byte, buffer_available, input ready);
  modport sink   (input valid, kind, rx_byte, buffer_available, output ready);
endinterface

[design/dsefr_out_if.sv]
interface dsefr_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic [7:0]  data_byte;
  logic [15:0] position;
  logic [15:0] frame_length;

  modport source (output valid, event_res, data_byte, position, frame_length, input ready);
  modport sink   (input valid, event_res, data_byte, position, frame_length, output ready);
endinterface

[design/dle_stx_etx_frame_receiver.sv]
// Channel    Dir  Handshake      Word
// words_i    in   valid/ready    kind, rx_byte, buffer_available
// results_o  out  valid/ready    event_res, data_byte, position, frame_length
// apb        in   psel/penable   max_payload at byte address 0
//
// One result word per input word, registered and shown in the cycle after acceptance.
// Sustained rate one word per clock while results are taken: the receiver state
// and the result register both update at the accepting edge.
// The result register frees itself when taken, so words_i stays ready while
// results_o is being read in the same cycle; it stalls only on a held result.
// rst_ni (async, low) returns the receiver to waiting for DLE, releases the
// buffer, clears the count and sets max_payload to 256.
module dle_stx_etx_frame_receiver (
  input  logic          clk_i,
  input  logic          rst_ni,
  dsefr_in_if.sink      words_i,
  dsefr_out_if.source   results_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  // ---- configuration ----
  logic [15:0] max_payload_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == dsefr_pkg::REG_MAX_PAYLOAD);
  assign prdata = (paddr[2] == dsefr_pkg::REG_MAX_PAYLOAD) ? {16'd0, max_payload_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= dsefr_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_wr) begin
      max_payload_q <= pwdata[15:0];
    end
  end

  // ---- receiver state ----
  dsefr_pkg::phase_e phase_q, phase_d;
  logic                          holds_q, holds_d;
  logic [dsefr_pkg::CountW-1:0]  count_q, count_d;
  logic [dsefr_pkg::CountW-1:0]  count_inc;
  logic                          store_ok;
  logic                          holds_stx;
  logic                          accept;
  logic                          in_ready;

  // result register
  logic        res_valid_q;
  logic [3:0]  res_event_q,  res_event_d;
  logic [7:0]  res_data_q,   res_data_d;
  logic [15:0] res_pos_q,    res_pos_d;
  logic [15:0] res_len_q,    res_len_d;

  assign in_ready      = !res_valid_q || results_o.ready;
  assign words_i.ready = in_ready;
  assign accept        = words_i.valid && in_ready;

  // saturating increment, then the limit check on the new count
  assign count_inc = (count_q == dsefr_pkg::COUNT_MAX) ? count_q
                                                      : count_q + {{(dsefr_pkg::CountW-1){1'b0}}, 1'b1};
  assign store_ok  = count_inc <= {1'b0, max_payload_q};
  // buffer held after an STX: keep one, else try to take one
  assign holds_stx = holds_q || words_i.buffer_available;

  // next state
  always_comb begin
    phase_d = phase_q;
    holds_d = holds_q;
    count_d = count_q;
    if (words_i.kind) begin
      phase_d = dsefr_pkg::PH_IDLE;
    end else begin
      unique case (phase_q)
        dsefr_pkg::PH_IDLE: begin
          if (words_i.rx_byte == dsefr_pkg::CH_DLE) phase_d = dsefr_pkg::PH_STX;
        end
        dsefr_pkg::PH_STX: begin
          if (words_i.rx_byte == dsefr_pkg::CH_STX) begin
            holds_d = holds_stx;
            if (holds_stx) begin
              count_d = '0;
              phase_d = dsefr_pkg::PH_DATA;
            end else begin
              phase_d = dsefr_pkg::PH_IDLE;
            end
          end else begin
            phase_d = dsefr_pkg::PH_IDLE;
          end
        end
        dsefr_pkg::PH_DATA: begin
          if (words_i.rx_byte == dsefr_pkg::CH_DLE) begin
            phase_d = dsefr_pkg::PH_ESC;
          end else begin
            count_d = count_inc;
            if (!store_ok) phase_d = dsefr_pkg::PH_IDLE;
          end
        end
        dsefr_pkg::PH_ESC: begin
          phase_d = dsefr_pkg::PH_DATA;
          if (words_i.rx_byte == dsefr_pkg::CH_STX) begin
            count_d = '0;          // restart inside a frame
          end else if (words_i.rx_byte == dsefr_pkg::CH_ETX) begin
            holds_d = 1'b0;        // buffer handed over
            phase_d = dsefr_pkg::PH_IDLE;
          end else if (words_i.rx_byte == dsefr_pkg::CH_DLE) begin
            count_d = count_inc;   // stuffed DLE
            if (!store_ok) phase_d = dsefr_pkg::PH_IDLE;
          end else begin
            phase_d = dsefr_pkg::PH_IDLE;
          end
        end
        default: phase_d = dsefr_pkg::PH_IDLE;
      endcase
    end
  end

  // result word
  always_comb begin
    res_event_d = dsefr_pkg::EV_NONE;
    res_data_d  = 8'd0;
    res_pos_d   = 16'd0;
    res_len_d   = 16'd0;
    if (words_i.kind) begin
      res_event_d = dsefr_pkg::EV_LINE;
    end else begin
      unique case (phase_q)
        dsefr_pkg::PH_IDLE: ;
        dsefr_pkg::PH_STX: begin
          if (words_i.rx_byte != dsefr_pkg::CH_STX) res_event_d = dsefr_pkg::EV_NOSTX;
          else if (!holds_stx)                     res_event_d = dsefr_pkg::EV_NOBUF;
        end
        dsefr_pkg::PH_DATA: begin
          if (words_i.rx_byte != dsefr_pkg::CH_DLE) begin
            if (store_ok) begin
              res_event_d = dsefr_pkg::EV_DATA;
              res_data_d  = words_i.rx_byte;
              res_pos_d   = dsefr_pkg::sat16(count_inc - {{(dsefr_pkg::CountW-1){1'b0}}, 1'b1});
            end else begin
              res_event_d = dsefr_pkg::EV_OVF;
            end
          end
        end
        dsefr_pkg::PH_ESC: begin
          if (words_i.rx_byte == dsefr_pkg::CH_STX) begin
            res_event_d = dsefr_pkg::EV_RESTART;
          end else if (words_i.rx_byte == dsefr_pkg::CH_ETX) begin
            res_event_d = dsefr_pkg::EV_DONE;
            res_len_d   = dsefr_pkg::sat16(count_q);
          end else if (words_i.rx_byte == dsefr_pkg::CH_DLE) begin
            if (store_ok) begin
              res_event_d = dsefr_pkg::EV_DATA;
              res_data_d  = dsefr_pkg::CH_DLE;
              res_pos_d   = dsefr_pkg::sat16(count_inc - {{(dsefr_pkg::CountW-1){1'b0}}, 1'b1});
            end else begin
              res_event_d = dsefr_pkg::EV_OVF;
            end
          end else begin
            res_event_d = dsefr_pkg::EV_BADESC;
          end
        end
        default: res_event_d = dsefr_pkg::EV_NONE;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= dsefr_pkg::PH_IDLE;
      holds_q     <= 1'b0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        holds_q <= holds_d;
        count_q <= count_d;
      end
      if (accept)                res_valid_q <= 1'b1;
      else if (results_o.ready)  res_valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_event_q <= res_event_d;
      res_data_q  <= res_data_d;
      res_pos_q   <= res_pos_d;
      res_len_q   <= res_len_d;
    end
  end

  assign results_o.valid        = res_valid_q;
  assign results_o.event_res    = res_event_q;
  assign results_o.data_byte    = res_data_q;
  assign results_o.position     = res_pos_q;
  assign results_o.frame_length = res_len_q;

  // ---- checks ----
  // never overwrite a result that is still held
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !results_o.ready) |-> !in_ready)
    else $error("input taken while result held");

  // a line error always reports as such on the next result
  a_line_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && words_i.kind) |=>
      (results_o.valid && results_o.event_res == dsefr_pkg::EV_LINE
       && phase_q == dsefr_pkg::PH_IDLE))
    else $error("line error not reported");

  // a data offset always lies below the payload limit
  a_pos_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (results_o.valid && results_o.event_res == dsefr_pkg::EV_DATA)
      |-> (results_o.position < max_payload_q))
    else $error("data offset beyond max_payload");

  // frame end releases the buffer
  a_done_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res_event_d == dsefr_pkg::EV_DONE) |=> (!holds_q && phase_q == dsefr_pkg::PH_IDLE))
    else $error("buffer kept after frame end");

endmodule
